>>> src/mipq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mipq_pkg
// Shared types and constants of the max-ID priority queue with a current slot.
// ----------------------------------------------------------------------------
package mipq_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int ID_WIDTH_DEF = 32;
    localparam int NODE_ID_W    = 32;
    localparam int COUNT_OUT_W  = 7;
    localparam int KIND_W       = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TAKE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic shl;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/mipq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mipq_cell
// One cell of the sorted row: holds one pending ID, compares it with the
// operation ID and shifts towards either neighbour.
// ----------------------------------------------------------------------------
module mipq_cell #(
    parameter int ID_WIDTH = mipq_pkg::ID_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mipq_pkg::cell_ctrl_t ctrl,
    input  wire logic [ID_WIDTH-1:0]  op_id,
    input  wire logic [ID_WIDTH-1:0]  left_id,
    input  wire logic                 left_valid,
    input  wire logic                 left_gt,
    input  wire logic [ID_WIDTH-1:0]  right_id,
    input  wire logic                 right_valid,
    output logic [ID_WIDTH-1:0]       id,
    output logic                      valid,
    output logic                      gt,
    output logic                      eq
);

    logic [ID_WIDTH-1:0] id_reg;
    logic [ID_WIDTH-1:0] id_next;
    logic                valid_reg;
    logic                valid_next;
    logic                gt_reg;
    logic                eq_reg;

    always_comb
    begin
        id_next    = id_reg;
        valid_next = valid_reg;
        if (ctrl.ins && !gt_reg)
        begin
            id_next    = left_gt ? op_id : left_id;
            valid_next = left_gt ? 1'b1 : left_valid;
        end
        else if (ctrl.shl)
        begin
            id_next    = right_id;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            gt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.cmp)
            begin
                gt_reg <= valid_reg && (id_reg > op_id);
                eq_reg <= valid_reg && (id_reg == op_id);
            end
        end
    end

    assign id    = id_reg;
    assign valid = valid_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule
`default_nettype wire

>>> src/max_id_priority_queue_with_current_unit.sv
// An input transfer is registered as the operation, then passes the compare
// pass and the shift pass through the cell row; the result register waits while
// it is held by out_stall. A new item is taken only once the shift pass is done.
// Reset clears every cell valid bit, the count and the current slot at once;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_id_priority_queue_with_current_unit
// Pending IDs kept sorted largest first in a row of cells, plus a current
// slot; insert, take, clear and query, one result per transfer.
// ----------------------------------------------------------------------------
module max_id_priority_queue_with_current_unit #(
    parameter int DEPTH    = mipq_pkg::DEPTH_DEF,
    parameter int ID_WIDTH = mipq_pkg::ID_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [mipq_pkg::KIND_W-1:0]       kind,
    input  wire logic [mipq_pkg::NODE_ID_W-1:0]    node_id,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   current_valid,
    output logic [mipq_pkg::NODE_ID_W-1:0]         current_id,
    output logic [mipq_pkg::COUNT_OUT_W-1:0]       queued_count,
    output logic                                   id_present,
    output logic                                   queue_empty,
    output logic                                   overflow
);
    import mipq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TOT_R = $clog2(DEPTH + 2);
    localparam int TOT_W = (TOT_R > COUNT_OUT_W) ? TOT_R : COUNT_OUT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [KIND_W-1:0]     op_kind_reg;
    logic [ID_WIDTH-1:0]   op_id_reg;
    logic                  cur_hit_reg;
    logic                  cur_valid_reg;
    logic                  cur_valid_next;
    logic [ID_WIDTH-1:0]   cur_id_reg;
    logic [ID_WIDTH-1:0]   cur_id_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic                  cur_valid_out_reg;
    logic [NODE_ID_W-1:0]  cur_id_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;
    logic                  present_out_reg;
    logic                  empty_out_reg;
    logic                  ovf_out_reg;

    logic                  apply_fire;
    logic                  any_eq;
    logic                  present_next;
    logic                  ovf_next;
    logic [TOT_W-1:0]      total;
    cell_ctrl_t            ctrl;

    logic [ID_WIDTH-1:0]   cell_id    [DEPTH];
    logic [DEPTH-1:0]      cell_valid;
    logic [DEPTH-1:0]      cell_gt;
    logic [DEPTH-1:0]      cell_eq;

    assign in_stall   = (state_reg != S_IDLE);
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || !out_stall);
    assign any_eq     = |cell_eq;

    always_comb
    begin
        ctrl           = '0;
        ctrl.cmp       = (state_reg == S_CMP);
        cur_valid_next = cur_valid_reg;
        cur_id_next    = cur_id_reg;
        count_next     = count_reg;
        present_next   = 1'b0;
        ovf_next       = 1'b0;
        if (apply_fire)
        begin
            unique case (op_kind_reg)
                KIND_INSERT:
                begin
                    if (!cur_hit_reg && !any_eq)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.ins   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                KIND_TAKE:
                begin
                    if (!cur_valid_reg && (count_reg != '0))
                    begin
                        ctrl.shl       = 1'b1;
                        cur_valid_next = 1'b1;
                        cur_id_next    = cell_id[0];
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                KIND_CLEAR:
                begin
                    cur_valid_next = 1'b0;
                    cur_id_next    = '0;
                end
                KIND_QUERY:
                begin
                    present_next = cur_hit_reg || any_eq;
                end
                default:
                begin
                    present_next = 1'b0;
                end
            endcase
        end
    end

    assign total = TOT_W'(count_next) + TOT_W'(cur_valid_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CMP;
            S_CMP:   state_next = S_APPLY;
            S_APPLY: if (apply_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_kind_reg <= kind;
            op_id_reg   <= ID_WIDTH'(node_id);
        end
        if (state_reg == S_CMP)
        begin
            cur_hit_reg <= cur_valid_reg && (cur_id_reg == op_id_reg);
        end
        if (apply_fire)
        begin
            cur_valid_out_reg <= cur_valid_next;
            cur_id_out_reg    <= NODE_ID_W'(cur_id_next);
            count_out_reg     <= total[COUNT_OUT_W-1:0];
            present_out_reg   <= present_next;
            empty_out_reg     <= (total == '0);
            ovf_out_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_valid_reg <= cur_valid_next;
            cur_id_reg    <= cur_id_next;
            count_reg     <= count_next;
            if (apply_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_WIDTH-1:0] l_id;
        logic                l_valid;
        logic                l_gt;
        logic [ID_WIDTH-1:0] r_id;
        logic                r_valid;

        if (i == 0)
        begin : g_first
            assign l_id    = '0;
            assign l_valid = 1'b0;
            assign l_gt    = 1'b1;
        end
        else
        begin : g_mid
            assign l_id    = cell_id[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_id    = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_inner
            assign r_id    = cell_id[i+1];
            assign r_valid = cell_valid[i+1];
        end

        mipq_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .op_id       (op_id_reg),
            .left_id     (l_id),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_id    (r_id),
            .right_valid (r_valid),
            .id          (cell_id[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i]),
            .eq          (cell_eq[i])
        );
    end

    assign out_valid     = out_valid_reg;
    assign current_valid = cur_valid_out_reg;
    assign current_id    = cur_id_out_reg;
    assign queued_count  = count_out_reg;
    assign id_present    = present_out_reg;
    assign queue_empty   = empty_out_reg;
    assign overflow      = ovf_out_reg;

endmodule
`default_nettype wire

>>> sim/tb_max_id_priority_queue_with_current_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_id_priority_queue_with_current_unit
// Drives inserts, takes, clears and queries into the max-ID queue with random
// gaps on the input side and random stalls on the result side. It tracks the
// pending set and the current slot itself, and compares every result with
// the status that it predicts.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                                  cur_valid;
    logic [mipq_pkg::NODE_ID_W-1:0]        cur_id;
    logic [mipq_pkg::COUNT_OUT_W-1:0]      count;
    logic                                  present;
    logic                                  empty;
    logic                                  ovf;
} queue_status_t;

class queue_tracker;
    bit [mipq_pkg::NODE_ID_W-1:0] ids [mipq_pkg::DEPTH_DEF];
    bit                           used [mipq_pkg::DEPTH_DEF];
    int                           n_pending;
    bit [mipq_pkg::NODE_ID_W-1:0] cur_id;
    bit                           cur_valid;
    queue_status_t                expected_status [$];
    int                           errors;
    int                           checked;

    function new();
        int i;
        for (i = 0; i < mipq_pkg::DEPTH_DEF; i++)
        begin
            ids[i]  = '0;
            used[i] = 1'b0;
        end
        n_pending = 0;
        cur_id    = '0;
        cur_valid = 1'b0;
        errors    = 0;
        checked   = 0;
    endfunction

    function void apply_op(logic [mipq_pkg::KIND_W-1:0] op,
                           logic [mipq_pkg::NODE_ID_W-1:0] id);
        queue_status_t r;
        int            i;
        int            slot;
        int            best;
        int            total;
        bit            hit;
        r    = '0;
        slot = -1;
        best = -1;
        hit  = 1'b0;
        for (i = 0; i < mipq_pkg::DEPTH_DEF; i++)
        begin
            if (used[i] && ids[i] == id)
                hit = 1'b1;
        end
        case (op)
            mipq_pkg::KIND_INSERT:
            begin
                if (!(cur_valid && cur_id == id) && !hit)
                begin
                    for (i = 0; i < mipq_pkg::DEPTH_DEF; i++)
                    begin
                        if (!used[i] && slot < 0)
                            slot = i;
                    end
                    if (slot < 0)
                        r.ovf = 1'b1;
                    else
                    begin
                        ids[slot]  = id;
                        used[slot] = 1'b1;
                        n_pending++;
                    end
                end
            end
            mipq_pkg::KIND_TAKE:
            begin
                if (!cur_valid)
                begin
                    for (i = 0; i < mipq_pkg::DEPTH_DEF; i++)
                    begin
                        if (used[i] && (best < 0 || ids[i] > ids[best]))
                            best = i;
                    end
                    if (best >= 0)
                    begin
                        cur_id     = ids[best];
                        cur_valid  = 1'b1;
                        used[best] = 1'b0;
                        n_pending--;
                    end
                end
            end
            mipq_pkg::KIND_CLEAR:
            begin
                cur_valid = 1'b0;
                cur_id    = '0;
            end
            default:
            begin
                r.present = (cur_valid && cur_id == id) || hit;
            end
        endcase
        total       = n_pending + (cur_valid ? 1 : 0);
        r.cur_valid = cur_valid;
        r.cur_id    = cur_valid ? cur_id : '0;
        r.count     = total[mipq_pkg::COUNT_OUT_W-1:0];
        r.empty     = (total == 0);
        expected_status.push_back(r);
    endfunction

    function void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, exp_v, act_v);
        end
    endfunction

    function void check_status(queue_status_t got);
        queue_status_t exp_s;
        checked++;
        if (expected_status.size() == 0)
        begin
            errors++;
            $display("%0t ns: result with no transfer waiting, actual %h", $time, got);
        end
        else
        begin
            exp_s = expected_status.pop_front();
            report_field("current_valid", exp_s.cur_valid, got.cur_valid);
            report_field("current_id", exp_s.cur_id, got.cur_id);
            report_field("queued_count", exp_s.count, got.count);
            report_field("id_present", exp_s.present, got.present);
            report_field("queue_empty", exp_s.empty, got.empty);
            report_field("overflow", exp_s.ovf, got.ovf);
        end
    endfunction

    function bit [mipq_pkg::NODE_ID_W-1:0] pick_pending();
        int i;
        int s;
        s = $urandom_range(0, mipq_pkg::DEPTH_DEF - 1);
        for (i = 0; i < mipq_pkg::DEPTH_DEF; i++)
        begin
            if (used[(s + i) % mipq_pkg::DEPTH_DEF])
                return ids[(s + i) % mipq_pkg::DEPTH_DEF];
        end
        return $urandom();
    endfunction

    function int outstanding();
        return expected_status.size();
    endfunction
endclass

module tb_max_id_priority_queue_with_current_unit;
    import mipq_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int ITEM_GOAL  = 1150;
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_LEN   = 120;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [KIND_W-1:0]      kind;
    logic [NODE_ID_W-1:0]   node_id;
    logic                   out_valid;
    logic                   out_stall;
    logic                   current_valid;
    logic [NODE_ID_W-1:0]   current_id;
    logic [COUNT_OUT_W-1:0] queued_count;
    logic                   id_present;
    logic                   queue_empty;
    logic                   overflow;

    queue_tracker sb;
    int           items_sent;
    int           gap_mode;

    max_id_priority_queue_with_current_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .node_id       (node_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .current_valid (current_valid),
        .current_id    (current_id),
        .queued_count  (queued_count),
        .id_present    (id_present),
        .queue_empty   (queue_empty),
        .overflow      (overflow)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (gap_mode == 0 || r < 12)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    task automatic send_item(logic [KIND_W-1:0] op, logic [NODE_ID_W-1:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        node_id  <= id;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.apply_op(op, id);
        items_sent++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic fill_store();
        int r;
        if (!sb.cur_valid)
        begin
            send_item(KIND_INSERT, $urandom());
            send_item(KIND_TAKE, $urandom());
        end
        while (sb.n_pending < DEPTH)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                send_item(KIND_INSERT, sb.pick_pending());
            else if (r == 1)
                send_item(KIND_QUERY, sb.pick_pending());
            else
                send_item(KIND_INSERT, $urandom());
        end
        repeat ($urandom_range(2, 5))
        begin
            r = $urandom_range(0, 3);
            if (r < 2)
                send_item(KIND_INSERT, $urandom());
            else if (r == 2)
                send_item(KIND_INSERT, sb.pick_pending());
            else
                send_item(KIND_INSERT, sb.cur_id);
        end
    endtask

    task automatic drain_store();
        int r;
        while (sb.n_pending + (sb.cur_valid ? 1 : 0) > 0)
        begin
            r = $urandom_range(0, 5);
            if (r == 0)
                send_item(KIND_QUERY, sb.pick_pending());
            else if (r == 1)
                send_item(KIND_QUERY, sb.cur_id);
            else if (r < 4)
                send_item(KIND_TAKE, $urandom());
            else
                send_item(KIND_CLEAR, $urandom());
        end
    endtask

    task automatic mixed_ops();
        logic [NODE_ID_W-1:0] pool [12];
        int                   i;
        int                   r;
        for (i = 0; i < 12; i++)
        begin
            r = $urandom_range(0, 5);
            if (r == 0)
                pool[i] = '0;
            else if (r == 1)
                pool[i] = '1;
            else if (r == 2)
                pool[i] = $urandom_range(0, 15);
            else
                pool[i] = $urandom();
        end
        repeat (40)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(KIND_W'($urandom_range(0, 3)), $urandom());
            else
                send_item(KIND_W'($urandom_range(0, 3)), pool[$urandom_range(0, 11)]);
        end
    endtask

    initial
    begin : stimulus
        int phase_no;
        int r;
        sb         = new();
        items_sent = 0;
        gap_mode   = 1;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        kind       <= KIND_INSERT;
        node_id    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(KIND_QUERY, 32'h0000_0000);
        send_item(KIND_TAKE, 32'h0000_0000);
        send_item(KIND_CLEAR, 32'h0000_0000);
        send_item(KIND_INSERT, 32'h0000_0000);
        send_item(KIND_INSERT, 32'hFFFF_FFFF);
        send_item(KIND_INSERT, 32'h0000_0000);
        send_item(KIND_INSERT, 32'h8000_0000);
        send_item(KIND_QUERY, 32'hFFFF_FFFF);
        send_item(KIND_QUERY, 32'h1234_5678);
        send_item(KIND_TAKE, 32'h0000_0000);
        send_item(KIND_INSERT, 32'hFFFF_FFFF);
        send_item(KIND_TAKE, 32'h0000_0000);
        send_item(KIND_QUERY, 32'hFFFF_FFFF);
        send_item(KIND_CLEAR, 32'hFFFF_FFFF);
        send_item(KIND_QUERY, 32'hFFFF_FFFF);
        send_item(KIND_TAKE, 32'h0000_0000);
        send_item(KIND_CLEAR, 32'h0000_0000);
        send_item(KIND_TAKE, 32'h0000_0000);
        send_item(KIND_QUERY, 32'h0000_0000);
        send_item(KIND_CLEAR, 32'h0000_0000);
        send_item(KIND_INSERT, 32'h5555_5555);
        send_item(KIND_INSERT, 32'hAAAA_AAAA);
        send_item(KIND_QUERY, 32'hAAAA_AAAA);

        phase_no = 0;
        while (items_sent < ITEM_GOAL)
        begin
            if (phase_no == 2 || $urandom_range(0, 3) == 0)
                wait_all_results();
            gap_mode = $urandom_range(0, 2);
            r = $urandom_range(0, 5);
            if (phase_no == 0 || r == 0)
                fill_store();
            else if (phase_no == 1 || r == 1)
                drain_store();
            else
                mixed_ops();
            phase_no++;
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : result_sink
        queue_status_t got;
        int            hold_left;
        int            run_left;
        bit            stalled;
        bit            held;
        hold_left = 0;
        run_left  = 0;
        stalled   = 1'b0;
        held      = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got.cur_valid = current_valid;
                got.cur_id    = current_id;
                got.count     = queued_count;
                got.present   = id_present;
                got.empty     = queue_empty;
                got.ovf       = overflow;
                sb.check_status(got);
            end
            // hold off once for a long stretch so that the block backs up
            if (!held && sb.checked >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stalled = 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalled = ($urandom_range(0, 2) == 0);
                    if ($urandom_range(0, 7) == 0)
                        run_left = $urandom_range(8, 30);
                    else
                        run_left = $urandom_range(1, 3);
                end
                run_left--;
            end
            out_stall <= stalled;
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
